>>> rtl/tlg_pkg.sv
// Shared types, constants and helpers for the toroidal life generation step core.
package tlg_pkg;

  localparam int GRID_SIDE_DEF = 64;

  localparam int          CELL_W    = 8;
  localparam int          LIVE_W    = 13;
  localparam logic [7:0]  Q_ONE     = 8'd128;
  localparam logic [7:0]  BIRTH_RST = 8'd48;
  localparam logic [12:0] LIVE_MAX  = 13'h1FFF;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] cell_value;
  } tlg_in_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic [12:0] live_count;
  } tlg_out_t;

  function automatic logic [7:0] sat_q(input logic [7:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

>>> rtl/toroidal_life_generation_step_core.sv
// Top level of the toroidal life generation step core.
//
// Usage: one input beat carries a request (write cell, read cell, advance one
// generation) and every input beat yields exactly one output beat. Both channels
// use valid and stall. The birth value register is written through cfg_we and
// cfg_wdata; the user must write it only while the core is idle, which the core
// itself does not enforce. Values above 1.0 saturate to 1.0. A write or an
// unused request code gives its output beat in the cycle after acceptance; a
// read passes through the read-wait state with its registered memory read. An
// advance streams the grid with a one-cell wrap border, one memory read per
// cycle, and drains its pipeline. One request is in work at a time, so an
// advance sets the throughput. After reset the core sweeps every address of
// the active grid bank to zero and stalls the input channel meanwhile.
// While the receiver stalls an output beat, the beat holds and the input channel
// stalls too. A generation writes the other bank and the banks swap at its end.
module toroidal_life_generation_step_core #(
  parameter int GRID_SIDE = tlg_pkg::GRID_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tlg_pkg::tlg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tlg_pkg::tlg_out_t out_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  import tlg_pkg::*;

  localparam int RB        = $clog2(GRID_SIDE);
  localparam int AW        = 2 * RB;
  localparam int PAD       = GRID_SIDE + 2;
  localparam int PB        = $clog2(PAD);
  localparam int CHAIN_LEN = 2 * PAD + 3;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CLEAR  = 2'd1;
  localparam logic [1:0] ST_RDWAIT = 2'd2;
  localparam logic [1:0] ST_STEP   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic              bank_r;
  logic [AW-1:0]     clr_addr_r;
  logic [7:0]        birth_r;
  logic              out_valid_r;
  tlg_out_t          out_data_r;
  logic              rd_on_grid_r;
  logic [PB-1:0]     pr_r, pc_r;
  logic              issue_done_r;
  logic              s1_valid_r;
  logic [PB-1:0]     s1_pr_r, s1_pc_r;
  logic              s2_valid_r;
  logic [AW-1:0]     s2_addr_r;
  logic [LIVE_W-1:0] live_r;

  logic              in_accept;
  logic              on_grid;
  logic [AW-1:0]     user_addr;
  logic [AW-1:0]     addr_a, addr_b, addr_b_step;
  logic              s1_center;
  logic              finish;
  logic              act_we;
  logic [AW-1:0]     act_waddr;
  logic [7:0]        act_wdata;
  logic              we0, we1;
  logic [AW-1:0]     waddr0, waddr1;
  logic [7:0]        wdata0, wdata1;
  logic [7:0]        rdata_a0, rdata_a1, rdata_b0, rdata_b1;
  logic [7:0]        rd_a, rd_b;
  logic [CHAIN_LEN-1:0] chain_q;
  logic [3:0]        nbr_cnt;
  logic [7:0]        new_val;

  function automatic logic [RB-1:0] pad_to_real(input logic [PB-1:0] p);
    if (p == '0) begin
      return RB'(GRID_SIDE - 1);
    end else if (p == PB'(PAD - 1)) begin
      return '0;
    end else begin
      return RB'(p - PB'(1));
    end
  endfunction

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign on_grid   = (32'(in_data.row) < 32'(GRID_SIDE)) &&
                     (32'(in_data.col) < 32'(GRID_SIDE));
  assign user_addr = {RB'(in_data.row), RB'(in_data.col)};

  assign addr_a      = {pad_to_real(pr_r), pad_to_real(pc_r)};
  assign addr_b_step = {RB'(s1_pr_r - PB'(2)), RB'(s1_pc_r - PB'(2))};
  assign addr_b      = (state_r == ST_STEP) ? addr_b_step : user_addr;
  assign s1_center   = s1_valid_r && (s1_pr_r >= PB'(2)) && (s1_pc_r >= PB'(2));
  assign finish      = (state_r == ST_STEP) && issue_done_r && !s1_valid_r && !s2_valid_r;

  assign act_we    = (state_r == ST_CLEAR) ||
                     (in_accept && (in_data.req_type == REQ_WRITE) && on_grid);
  assign act_waddr = (state_r == ST_CLEAR) ? clr_addr_r : user_addr;
  assign act_wdata = (state_r == ST_CLEAR) ? 8'd0 : sat_q(in_data.cell_value);

  assign we0    = bank_r ? s2_valid_r : act_we;
  assign waddr0 = bank_r ? s2_addr_r  : act_waddr;
  assign wdata0 = bank_r ? new_val    : act_wdata;
  assign we1    = bank_r ? act_we     : s2_valid_r;
  assign waddr1 = bank_r ? act_waddr  : s2_addr_r;
  assign wdata1 = bank_r ? act_wdata  : new_val;

  tlg_ram #(.AW(AW), .DW(CELL_W)) u_bank0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rdata_a0),
    .rdata_b (rdata_b0)
  );

  tlg_ram #(.AW(AW), .DW(CELL_W)) u_bank1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr1),
    .wdata   (wdata1),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rdata_a1),
    .rdata_b (rdata_b1)
  );

  assign rd_a = bank_r ? rdata_a1 : rdata_a0;
  assign rd_b = bank_r ? rdata_b1 : rdata_b0;

  genvar gi;
  generate
    for (gi = 0; gi < CHAIN_LEN; gi++) begin : g_chain
      if (gi == 0) begin : g_head
        tlg_cell u_cell (
          .clk      (clk),
          .shift_en (s1_valid_r),
          .d_in     (rd_a != 8'd0),
          .q_out    (chain_q[gi])
        );
      end else begin : g_body
        tlg_cell u_cell (
          .clk      (clk),
          .shift_en (s1_valid_r),
          .d_in     (chain_q[gi-1]),
          .q_out    (chain_q[gi])
        );
      end
    end
  endgenerate

  assign nbr_cnt = 4'(chain_q[0]) + 4'(chain_q[1]) + 4'(chain_q[2]) +
                   4'(chain_q[PAD]) + 4'(chain_q[PAD+2]) +
                   4'(chain_q[2*PAD]) + 4'(chain_q[2*PAD+1]) + 4'(chain_q[2*PAD+2]);

  always_comb begin
    if (rd_b != 8'd0) begin
      new_val = ((nbr_cnt == 4'd2) || (nbr_cnt == 4'd3)) ? rd_b : 8'd0;
    end else begin
      new_val = (nbr_cnt == 4'd3) ? birth_r : 8'd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && (in_data.req_type == REQ_READ)) begin
          state_nxt = ST_RDWAIT;
        end else if (in_accept && (in_data.req_type == REQ_ADVANCE)) begin
          state_nxt = ST_STEP;
        end
      end
      ST_RDWAIT: begin
        state_nxt = ST_IDLE;
      end
      ST_STEP: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      bank_r       <= 1'b0;
      clr_addr_r   <= '0;
      birth_r      <= BIRTH_RST;
      out_valid_r  <= 1'b0;
      issue_done_r <= 1'b1;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      live_r       <= '0;
      pr_r         <= '0;
      pc_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        birth_r <= sat_q(cfg_wdata);
      end
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_accept) begin
        case (in_data.req_type)
          REQ_READ: begin
            rd_on_grid_r <= on_grid;
          end
          REQ_ADVANCE: begin
            pr_r         <= '0;
            pc_r         <= '0;
            issue_done_r <= 1'b0;
            live_r       <= '0;
          end
          default: begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
          end
        endcase
      end
      if (state_r == ST_RDWAIT) begin
        out_valid_r           <= 1'b1;
        out_data_r.read_value <= rd_on_grid_r ? rd_b : 8'd0;
        out_data_r.live_count <= '0;
      end
      if ((state_r == ST_STEP) && !issue_done_r) begin
        if (pc_r == PB'(PAD - 1)) begin
          pc_r <= '0;
          if (pr_r == PB'(PAD - 1)) begin
            issue_done_r <= 1'b1;
          end else begin
            pr_r <= pr_r + PB'(1);
          end
        end else begin
          pc_r <= pc_r + PB'(1);
        end
      end
      s1_valid_r <= (state_r == ST_STEP) && !issue_done_r;
      s2_valid_r <= s1_center;
      if (s2_valid_r && (new_val != 8'd0) && (live_r != LIVE_MAX)) begin
        live_r <= live_r + LIVE_W'(1);
      end
      if (finish) begin
        out_valid_r           <= 1'b1;
        out_data_r.read_value <= 8'd0;
        out_data_r.live_count <= live_r;
        bank_r                <= ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pr_r   <= pr_r;
    s1_pc_r   <= pc_r;
    s2_addr_r <= addr_b_step;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_center_match: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (chain_q[PAD+1] == (rd_b != 8'd0)))
    else $error("Window center disagrees with the center cell read.");

  a_write_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (state_r == ST_STEP))
    else $error("Generation write outside an advance.");

  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_r != $past(bank_r)) |-> ($past(state_r) == ST_STEP))
    else $error("Grid banks swapped outside the end of an advance.");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("Output beat offered during the clearing sweep.");

endmodule

>>> rtl/tlg_cell.sv
// One stage of the liveness shift chain that forms the three-row neighbor window.
module tlg_cell (
  input  logic clk,
  input  logic shift_en,
  input  logic d_in,
  output logic q_out
);

  logic live_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      live_r <= d_in;
    end
  end

  assign q_out = live_r;

endmodule

>>> rtl/tlg_ram.sv
// Grid bank memory with one write port and two registered read ports.
module tlg_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule
